// File: rtl/core/urs_pkg.sv
package urs_pkg;

   localparam int NUM_SENSORS = 3;
   localparam int TICK_W      = 8;
   localparam int DIST_W      = 10;
   localparam int STAMP_W     = 16;
   localparam int PERIOD_W    = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;

   // command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_ECHO = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SLOT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_DISTANCE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MAX     = 3'd4;

   // register reset values
   localparam logic [TICK_W-1:0]   RST_TICKS_PER_SLOT = 8'd5;
   localparam logic [DIST_W-1:0]   RST_WARN_DISTANCE  = 10'd40;
   localparam logic [DIST_W-1:0]   RST_MAX_DISTANCE   = 10'd380;
   localparam logic [PERIOD_W-1:0] RST_PERIOD_MIN     = 4'd1;
   localparam logic [PERIOD_W-1:0] RST_PERIOD_MAX     = 4'd4;

   // echo time to cm: x/116 = (x * 36158) >> 22, exact for 16-bit x
   localparam logic [15:0] ECHO_RECIP       = 16'd36158;
   localparam int          ECHO_RECIP_SHIFT = 22;
   // distance/10 = (d * 820) >> 13, exact for 10-bit d
   localparam logic [9:0]  TEN_RECIP        = 10'd820;
   localparam int          TEN_RECIP_SHIFT  = 13;

   typedef logic [DIST_W-1:0] dist_type;
   typedef dist_type [NUM_SENSORS-1:0] dist_vec_type;

   typedef struct packed {
      logic [TICK_W-1:0]   ticks_per_slot;
      logic [DIST_W-1:0]   warn_distance;
      logic [DIST_W-1:0]   max_valid_distance;
      logic [PERIOD_W-1:0] alarm_period_min;
      logic [PERIOD_W-1:0] alarm_period_max;
   } cfg_type;

   typedef struct packed {
      logic               command;
      logic [1:0]         echo_channel;
      logic [STAMP_W-1:0] timer_stamp;
   } req_word_type;

   typedef struct packed {
      logic       fire;
      logic [1:0] sensor;
   } arm_type;

   typedef struct packed {
      logic buzzer;
      logic lamp;
      logic flag;
   } alarm_type;

   typedef struct packed {
      logic [1:0]   trigger_channel;
      dist_vec_type distance;
      alarm_type    alarm;
   } rsp_word_type;

endpackage

// File: rtl/core/urs_if.sv
interface urs_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [1:0]  echo_channel;
   logic [15:0] timer_stamp;

   modport source (output valid, command, echo_channel, timer_stamp, input ready);
   modport sink   (input valid, command, echo_channel, timer_stamp, output ready);
endinterface

interface urs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] trigger_channel;
   logic [9:0] distance_first;
   logic [9:0] distance_second;
   logic [9:0] distance_third;
   logic       buzzer_on;
   logic       lamp_off;
   logic       alarm_active;

   modport source (output valid, trigger_channel, distance_first, distance_second,
                   distance_third, buzzer_on, lamp_off, alarm_active, input ready);
   modport sink   (input valid, trigger_channel, distance_first, distance_second,
                   distance_third, buzzer_on, lamp_off, alarm_active, output ready);
endinterface

interface urs_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [9:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/urs_csr.sv
module urs_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [urs_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [urs_pkg::CSR_DATA_W-1:0] wr_data,
   output urs_pkg::cfg_type             cfg
);
   import urs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_TICKS_PER_SLOT: cfg_in.ticks_per_slot     = wr_data[TICK_W-1:0];
            CSR_WARN_DISTANCE:  cfg_in.warn_distance      = wr_data[DIST_W-1:0];
            CSR_MAX_DISTANCE:   cfg_in.max_valid_distance = wr_data[DIST_W-1:0];
            CSR_PERIOD_MIN:     cfg_in.alarm_period_min   = wr_data[PERIOD_W-1:0];
            CSR_PERIOD_MAX:     cfg_in.alarm_period_max   = wr_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_slot     <= RST_TICKS_PER_SLOT;
         cfg_ff.warn_distance      <= RST_WARN_DISTANCE;
         cfg_ff.max_valid_distance <= RST_MAX_DISTANCE;
         cfg_ff.alarm_period_min   <= RST_PERIOD_MIN;
         cfg_ff.alarm_period_max   <= RST_PERIOD_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/urs_echo.sv
module urs_echo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_echo,
   input  logic [1:0]                  echo_channel,
   input  logic [urs_pkg::STAMP_W-1:0] timer_stamp,
   input  urs_pkg::arm_type            arm,
   input  logic [urs_pkg::DIST_W-1:0]  max_valid_distance,
   output urs_pkg::dist_vec_type       dist_cur,
   output urs_pkg::dist_vec_type       dist_next
);
   import urs_pkg::*;

   logic [1:0]                   armed_ff, armed_in;
   logic [NUM_SENSORS-1:0]       seen_ff, seen_in;
   logic [STAMP_W-1:0]           start_ff [NUM_SENSORS];
   logic [STAMP_W-1:0]           start_in [NUM_SENSORS];
   dist_vec_type                 dist_ff, dist_in;

   logic                         ch_ok;
   logic                         hit;
   logic [STAMP_W-1:0]           start_sel;
   logic [STAMP_W-1:0]           diff;
   logic [2*STAMP_W-1:0]         prod;
   logic [DIST_W-1:0]            meas;

   assign ch_ok     = (echo_channel != 2'd3);
   assign hit       = ch_ok && (armed_ff == (echo_channel + 2'd1));
   assign start_sel = ch_ok ? start_ff[echo_channel] : '0;
   assign diff      = timer_stamp - start_sel;
   assign prod      = diff * ECHO_RECIP;
   assign meas      = prod[ECHO_RECIP_SHIFT +: DIST_W];

   always_comb begin
      armed_in = armed_ff;
      seen_in  = seen_ff;
      start_in = start_ff;
      dist_in  = dist_ff;
      if (arm.fire) begin
         armed_in = arm.sensor;
      end else if (step_echo && hit) begin
         if (!seen_ff[echo_channel]) begin
            start_in[echo_channel] = timer_stamp;
            seen_in[echo_channel]  = 1'b1;
         end else begin
            // drop readings beyond the limit, keep the old distance
            if (meas <= max_valid_distance) begin
               dist_in[echo_channel] = meas;
            end
            seen_in[echo_channel] = 1'b0;
            armed_in              = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 2'd1;
         seen_ff  <= '0;
         dist_ff  <= '0;
         for (int i = 0; i < NUM_SENSORS; i++) begin
            start_ff[i] <= '0;
         end
      end else begin
         armed_ff <= armed_in;
         seen_ff  <= seen_in;
         start_ff <= start_in;
         dist_ff  <= dist_in;
      end
   end

   assign dist_cur  = dist_ff;
   assign dist_next = dist_in;

endmodule

// File: rtl/core/urs_sched.sv
module urs_sched (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_tick,
   input  urs_pkg::cfg_type           cfg,
   input  logic [urs_pkg::DIST_W-1:0] dist_first,
   output urs_pkg::arm_type           arm,
   output urs_pkg::alarm_type         alarm_next
);
   import urs_pkg::*;

   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [1:0]          slot_ff, slot_in;
   logic [PERIOD_W-1:0] count_ff, count_in;
   alarm_type           alarm_ff, alarm_in;

   logic [TICK_W-1:0]   tick_inc;
   logic                fire;
   logic [19:0]         prod;
   logic [6:0]          period_raw;
   logic [6:0]          period_lo;
   logic [6:0]          period;
   logic [PERIOD_W-1:0] count_inc;
   logic                near;

   assign tick_inc   = tick_ff + 8'd1;
   assign fire       = step_tick && (tick_inc >= cfg.ticks_per_slot);

   // period = distance/10 + 1, min clamp first so max wins on a crossing
   assign prod       = dist_first * TEN_RECIP;
   assign period_raw = prod[TEN_RECIP_SHIFT +: 7] + 7'd1;
   assign period_lo  = (period_raw <= {3'd0, cfg.alarm_period_min}) ?
                       {3'd0, cfg.alarm_period_min} : period_raw;
   assign period     = (period_lo >= {3'd0, cfg.alarm_period_max}) ?
                       {3'd0, cfg.alarm_period_max} : period_lo;
   assign near       = (dist_first <= cfg.warn_distance);
   assign count_inc  = count_ff + 4'd1;

   always_comb begin
      tick_in  = tick_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      alarm_in = alarm_ff;
      if (step_tick) begin
         tick_in = tick_inc;
      end
      if (fire) begin
         tick_in        = '0;
         slot_in        = (slot_ff >= 2'd3) ? 2'd1 : slot_ff + 2'd1;
         alarm_in.flag  = near;
         if (near) begin
            count_in = count_inc;
            if ({3'd0, count_inc} >= period) begin
               alarm_in.buzzer = ~alarm_ff.buzzer;
               alarm_in.lamp   = ~alarm_ff.lamp;
               count_in        = '0;
            end
         end else begin
            alarm_in.buzzer = 1'b0;
            alarm_in.lamp   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff         <= '0;
         slot_ff         <= 2'd1;
         count_ff        <= '0;
         alarm_ff.buzzer <= 1'b0;
         alarm_ff.lamp   <= 1'b1;
         alarm_ff.flag   <= 1'b0;
      end else begin
         tick_ff  <= tick_in;
         slot_ff  <= slot_in;
         count_ff <= count_in;
         alarm_ff <= alarm_in;
      end
   end

   assign arm.fire    = fire;
   assign arm.sensor  = slot_in;
   assign alarm_next  = alarm_in;

endmodule

// File: rtl/core/ultrasonic_ranging_scheduler_alarm_top.sv
// A word accepted on req_ch passes the input register, then the update logic
// into the result register, before it shows on rsp_ch.
// Throughput: one word per cycle unless rsp_ch stalls; divides by 116 and 10
// are constant reciprocal multiplies, so the state update is combinational.
// Reset is synchronous and active high; it empties both registers and loads
// the power-up state and register defaults.
module ultrasonic_ranging_scheduler_alarm_top (
   input  logic       clock,
   input  logic       reset,
   urs_req_if.sink    req_ch,
   urs_rsp_if.source  rsp_ch,
   urs_csr_if.sink    csr_ch
);
   import urs_pkg::*;

   cfg_type       cfg;
   req_word_type  in_word_ff, in_word_in;
   logic          in_valid_ff, in_valid_in;
   rsp_word_type  out_word_ff, out_word_in;
   logic          out_valid_ff, out_valid_in;
   logic          adv;
   logic          step_tick;
   logic          step_echo;
   arm_type       arm;
   alarm_type     alarm_next;
   dist_vec_type  dist_cur, dist_next;

   assign adv       = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign step_tick = adv && (in_word_ff.command == CMD_TICK);
   assign step_echo = adv && (in_word_ff.command == CMD_ECHO);

   assign req_ch.ready = !in_valid_ff || adv;
   assign csr_ch.ready = 1'b1;

   urs_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   urs_sched u_sched (
      .clock      (clock),
      .reset      (reset),
      .step_tick  (step_tick),
      .cfg        (cfg),
      .dist_first (dist_cur[0]),
      .arm        (arm),
      .alarm_next (alarm_next)
   );

   urs_echo u_echo (
      .clock              (clock),
      .reset              (reset),
      .step_echo          (step_echo),
      .echo_channel       (in_word_ff.echo_channel),
      .timer_stamp        (in_word_ff.timer_stamp),
      .arm                (arm),
      .max_valid_distance (cfg.max_valid_distance),
      .dist_cur           (dist_cur),
      .dist_next          (dist_next)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in             = 1'b1;
         in_word_in.command      = req_ch.command;
         in_word_in.echo_channel = req_ch.echo_channel;
         in_word_in.timer_stamp  = req_ch.timer_stamp;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (adv) begin
         out_valid_in                = 1'b1;
         out_word_in.trigger_channel = arm.fire ? arm.sensor : 2'd0;
         out_word_in.distance        = dist_next;
         out_word_in.alarm           = alarm_next;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold payload until the next word moves in
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.trigger_channel = out_word_ff.trigger_channel;
   assign rsp_ch.distance_first  = out_word_ff.distance[0];
   assign rsp_ch.distance_second = out_word_ff.distance[1];
   assign rsp_ch.distance_third  = out_word_ff.distance[2];
   assign rsp_ch.buzzer_on       = out_word_ff.alarm.buzzer;
   assign rsp_ch.lamp_off        = out_word_ff.alarm.lamp;
   assign rsp_ch.alarm_active    = out_word_ff.alarm.flag;

endmodule
